// ----- sv/lik_pkg.sv -----
package lik_pkg;

    localparam int COORD_W           = 16;
    localparam int LEN_W             = 14;
    localparam int ANG_W             = 16;
    localparam int FEMUR_W           = 17;
    localparam int ACC_W             = 34;
    localparam int CORDIC_IN_W       = 32;
    localparam int FRAC_W            = 16;
    localparam int TAB_LEN           = 24;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int CFG_IDX_W         = 2;

    localparam logic [CFG_IDX_W-1:0] REG_COXA  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FEMUR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIBIA = 2'd2;

    localparam logic [LEN_W-1:0] COXA_RST  = 14'd4160;
    localparam logic [LEN_W-1:0] FEMUR_RST = 14'd4160;
    localparam logic [LEN_W-1:0] TIBIA_RST = 14'd6080;

    // half turn in accumulator units (2^16 steps per 1/128 degree)
    localparam logic signed [ACC_W-1:0] HALF_TURN = 34'sd1509949440;
    localparam logic signed [ANG_W-1:0] COXA_LIM  = 16'sd23040;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_REACH = 2'd1,
        ST_COS   = 2'd2,
        ST_ZERO  = 2'd3
    } status_t;

    localparam logic [28:0] ATAN_TAB [0:TAB_LEN-1] = '{
        29'd377487360, 29'd222843801, 29'd117744544, 29'd59768969,
        29'd30000467,  29'd15014858,  29'd7509261,   29'd3754860,
        29'd1877459,   29'd938733,    29'd469367,    29'd234683,
        29'd117342,    29'd58671,     29'd29335,     29'd14668,
        29'd7334,      29'd3667,      29'd1833,      29'd917,
        29'd458,       29'd229,       29'd115,       29'd57
    };

    // drop FRAC_W fraction bits, half away from zero
    function automatic logic signed [19:0] rnd16(input logic signed [ACC_W:0] v);
        logic [ACC_W:0] mag;
        logic [ACC_W:0] q;
        mag = v[ACC_W] ? $unsigned(-v) : $unsigned(v);
        q   = (mag + (ACC_W+1)'(32768)) >> FRAC_W;
        return v[ACC_W] ? -$signed(q[19:0]) : $signed(q[19:0]);
    endfunction

endpackage

// ----- sv/lik_isqrt.sv -----
module lik_isqrt #(
    parameter int W      = 32,
    parameter int LANES  = 1,
    parameter int SIDE_W = 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [LANES-1:0][W-1:0]     rad,
    input  logic [SIDE_W-1:0]           in_side,
    output logic                        out_valid,
    output logic [LANES-1:0][W/2-1:0]   root,
    output logic [SIDE_W-1:0]           out_side
);

    localparam int N = W / 2;

    logic [LANES-1:0][W-1:0] rem_reg [N];
    logic [LANES-1:0][W-1:0] rt_reg  [N];
    logic [SIDE_W-1:0]       side_reg [N];
    logic                    vld_reg [N];

    logic [LANES-1:0][W-1:0] rem_src  [N];
    logic [LANES-1:0][W-1:0] rt_src   [N];
    logic [LANES-1:0][W-1:0] rem_next [N];
    logic [LANES-1:0][W-1:0] rt_next  [N];

    // one result bit per stage, bit weight falls by 4 each stage
    always_comb
    begin
        logic [W:0]   trial;
        logic [W-1:0] bitv;
        rem_src[0] = rad;
        rt_src[0]  = '0;
        for (int k = 1; k < N; k++)
        begin
            rem_src[k] = rem_reg[k-1];
            rt_src[k]  = rt_reg[k-1];
        end
        for (int k = 0; k < N; k++)
        begin
            bitv = W'(1) << (2 * (N - 1 - k));
            for (int l = 0; l < LANES; l++)
            begin
                trial = {1'b0, rt_src[k][l]} + {1'b0, bitv};
                if ({1'b0, rem_src[k][l]} >= trial)
                begin
                    rem_next[k][l] = rem_src[k][l] - trial[W-1:0];
                    rt_next[k][l]  = (rt_src[k][l] >> 1) + bitv;
                end
                else
                begin
                    rem_next[k][l] = rem_src[k][l];
                    rt_next[k][l]  = rt_src[k][l] >> 1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < N; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k < N; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= in_side;
            for (int k = 1; k < N; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
            for (int k = 0; k < N; k++)
            begin
                rem_reg[k] <= rem_next[k];
                rt_reg[k]  <= rt_next[k];
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            root[l] = rt_reg[N-1][l][N-1:0];
        end
    end

    assign out_valid = vld_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

// ----- sv/lik_cordic.sv -----
module lik_cordic
    import lik_pkg::*;
#(
    parameter int STAGES = CORDIC_STAGES_DEF,
    parameter int LANES  = 1,
    parameter int SIDE_W = 1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [LANES-1:0][CORDIC_IN_W-1:0] yin,
    input  logic [LANES-1:0][CORDIC_IN_W-1:0] xin,
    input  logic [SIDE_W-1:0]                 in_side,
    output logic                              out_valid,
    output logic [LANES-1:0][ACC_W-1:0]       angle,
    output logic [SIDE_W-1:0]                 out_side
);

    // room for the fraction shift, gain of about 1.65 and the pre-rotation
    localparam int XY_W = CORDIC_IN_W + FRAC_W + 3;

    logic [LANES-1:0][XY_W-1:0]  x_reg    [STAGES+1];
    logic [LANES-1:0][XY_W-1:0]  y_reg    [STAGES+1];
    logic [LANES-1:0][ACC_W-1:0] acc_reg  [STAGES+1];
    logic [LANES-1:0]            zero_reg [STAGES+1];
    logic [SIDE_W-1:0]           side_reg [STAGES+1];
    logic                        vld_reg  [STAGES+1];

    logic [LANES-1:0][XY_W-1:0]  x_next   [STAGES+1];
    logic [LANES-1:0][XY_W-1:0]  y_next   [STAGES+1];
    logic [LANES-1:0][ACC_W-1:0] acc_next [STAGES+1];
    logic [LANES-1:0]            pre_zero;

    always_comb
    begin
        logic signed [XY_W-1:0]  xs;
        logic signed [XY_W-1:0]  ys;
        logic signed [ACC_W-1:0] as;
        logic signed [ACC_W-1:0] tab;
        // pre-rotation into the right half plane
        for (int l = 0; l < LANES; l++)
        begin
            xs = XY_W'($signed({xin[l], 16'h0}));
            ys = XY_W'($signed({yin[l], 16'h0}));
            pre_zero[l] = (xin[l] == '0) && (yin[l] == '0);
            if (xin[l][CORDIC_IN_W-1])
            begin
                acc_next[0][l] = ys[XY_W-1] ? -HALF_TURN : HALF_TURN;
                x_next[0][l]   = -xs;
                y_next[0][l]   = -ys;
            end
            else
            begin
                acc_next[0][l] = '0;
                x_next[0][l]   = xs;
                y_next[0][l]   = ys;
            end
        end
        for (int k = 0; k < STAGES; k++)
        begin
            tab = ACC_W'(ATAN_TAB[k]);
            for (int l = 0; l < LANES; l++)
            begin
                xs = $signed(x_reg[k][l]);
                ys = $signed(y_reg[k][l]);
                as = $signed(acc_reg[k][l]);
                if (!ys[XY_W-1] && (ys != '0))
                begin
                    x_next[k+1][l]   = xs + (ys >>> k);
                    y_next[k+1][l]   = ys - (xs >>> k);
                    acc_next[k+1][l] = as + tab;
                end
                else
                begin
                    x_next[k+1][l]   = xs - (ys >>> k);
                    y_next[k+1][l]   = ys + (xs >>> k);
                    acc_next[k+1][l] = as - tab;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= STAGES; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k <= STAGES; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= in_side;
            zero_reg[0] <= pre_zero;
            for (int k = 1; k <= STAGES; k++)
            begin
                side_reg[k] <= side_reg[k-1];
                zero_reg[k] <= zero_reg[k-1];
            end
            for (int k = 0; k <= STAGES; k++)
            begin
                x_reg[k]   <= x_next[k];
                y_reg[k]   <= y_next[k];
                acc_reg[k] <= acc_next[k];
            end
        end
    end

    // atan2(0, 0) is defined as zero
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            angle[l] = zero_reg[STAGES][l] ? '0 : acc_reg[STAGES][l];
        end
    end

    assign out_valid = vld_reg[STAGES];
    assign out_side  = side_reg[STAGES];

endmodule

// ----- sv/leg_inverse_kinematics_top.sv -----
// Requests that arrive while the pipeline is held wait in the input skid register.
// Throughput: one request per cycle; the path is square roots (one bit per stage) and CORDIC
//   (one rotation per stage), all under a single stall enable from the output register.
// Reset: pipeline and skid emptied, link lengths return to 4160 / 4160 / 6080.
module leg_inverse_kinematics_top
    import lik_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [47:0]          s_axis_tdata,   // target_x, target_y, target_z
    input  logic                 s_axis_tuser,   // knee_up
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [55:0]          m_axis_tdata,   // coxa_deg, femur_deg, tibia_deg, zero pad
    output logic [1:0]           m_axis_tuser,   // status
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LEN_W-1:0]     cfg_data
);

    typedef struct packed {
        logic                      up;
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } item_t;

    typedef struct packed {
        item_t              item;
        logic signed [16:0] h;
    } reach_t;

    typedef struct packed {
        item_t              item;
        logic signed [16:0] h;
        logic signed [31:0] num;
        logic signed [29:0] n2;
        status_t            status;
    } solve_t;

    typedef struct packed {
        logic    up;
        status_t status;
    } tag_t;

    function automatic logic signed [ACC_W-1:0] clamp_acc(
        input logic signed [ACC_W-1:0] v,
        input logic signed [ACC_W-1:0] lo,
        input logic signed [ACC_W-1:0] hi
    );
        if (v < lo)
        begin
            return lo;
        end
        else if (v > hi)
        begin
            return hi;
        end
        return v;
    endfunction

    logic en;

    // configuration
    logic [LEN_W-1:0] coxa_len_reg;
    logic [LEN_W-1:0] femur_len_reg;
    logic [LEN_W-1:0] tibia_len_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coxa_len_reg  <= COXA_RST;
            femur_len_reg <= FEMUR_RST;
            tibia_len_reg <= TIBIA_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_COXA:  coxa_len_reg  <= cfg_data;
                REG_FEMUR: femur_len_reg <= cfg_data;
                REG_TIBIA: tibia_len_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    // input skid register: takes a request while the pipeline is held
    item_t skid_reg;
    logic  skid_full_reg;
    item_t in_item;
    item_t front;
    logic  front_vld;

    assign in_item       = item_t'({s_axis_tuser, s_axis_tdata});
    assign s_axis_tready = !skid_full_reg;
    assign front         = skid_full_reg ? skid_reg : in_item;
    assign front_vld     = skid_full_reg || s_axis_tvalid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_full_reg <= 1'b0;
        end
        else if (en)
        begin
            skid_full_reg <= 1'b0;
        end
        else if (s_axis_tvalid)
        begin
            skid_full_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!en && s_axis_tvalid && !skid_full_reg)
        begin
            skid_reg <= in_item;
        end
    end

    // T1: x^2 + y^2
    item_t       t1_item_reg;
    logic [31:0] t1_sq_reg;
    logic        t1_vld_reg;
    logic [31:0] t1_sq_next;

    always_comb
    begin
        logic signed [31:0] xx;
        logic signed [31:0] yy;
        xx = front.x * front.x;
        yy = front.y * front.y;
        t1_sq_next = $unsigned(xx) + $unsigned(yy);
    end

    // horizontal radius
    logic        a_vld;
    logic [15:0] a_root;
    item_t       a_item;

    lik_isqrt #(
        .W      (32),
        .LANES  (1),
        .SIDE_W ($bits(item_t))
    ) u_isqrt_rad (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (t1_vld_reg),
        .rad       (t1_sq_reg),
        .in_side   (t1_item_reg),
        .out_valid (a_vld),
        .root      (a_root),
        .out_side  (a_item)
    );

    // T2: h = radius - coxa, z^2
    item_t              t2_item_reg;
    logic signed [16:0] t2_h_reg;
    logic [30:0]        t2_zz_reg;
    logic               t2_vld_reg;
    logic signed [16:0] t2_h_next;
    logic [30:0]        t2_zz_next;

    always_comb
    begin
        logic signed [31:0] zz;
        zz         = a_item.z * a_item.z;
        t2_zz_next = zz[30:0];
        t2_h_next  = $signed({1'b0, a_root}) - $signed({3'b0, coxa_len_reg});
    end

    // T3: h^2 + z^2
    reach_t      t3_side_reg;
    logic [31:0] t3_sum_reg;
    logic        t3_vld_reg;
    logic [31:0] t3_sum_next;

    always_comb
    begin
        logic signed [33:0] hh;
        hh          = t2_h_reg * t2_h_reg;
        t3_sum_next = hh[31:0] + 32'(t2_zz_reg);
    end

    // planar distance d
    logic        b_vld;
    logic [15:0] b_root;
    reach_t      b_side;

    lik_isqrt #(
        .W      (32),
        .LANES  (1),
        .SIDE_W ($bits(reach_t))
    ) u_isqrt_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (t3_vld_reg),
        .rad       (t3_sum_reg),
        .in_side   (t3_side_reg),
        .out_valid (b_vld),
        .root      (b_root),
        .out_side  (b_side)
    );

    // T4: products of link lengths and distance
    reach_t      t4_side_reg;
    logic [15:0] t4_d_reg;
    logic [27:0] t4_ff_reg;
    logic [27:0] t4_tt_reg;
    logic [31:0] t4_dd_reg;
    logic [30:0] t4_den_reg;
    logic [28:0] t4_den2_reg;
    logic        t4_vld_reg;
    logic [29:0] t4_fd;
    logic [27:0] t4_ft;

    assign t4_fd = 30'(femur_len_reg) * 30'(b_root);
    assign t4_ft = 28'(femur_len_reg) * 28'(tibia_len_reg);

    // T5: cosine numerators, status, clamps
    solve_t             t5_side_reg;
    logic [30:0]        t5_den_reg;
    logic [28:0]        t5_den2_reg;
    logic               t5_vld_reg;
    logic signed [31:0] t5_num_next;
    logic signed [29:0] t5_n2_next;
    status_t            t5_status_next;

    always_comb
    begin
        logic signed [34:0] num_w;
        logic signed [34:0] n2_w;
        logic signed [34:0] den_w;
        logic signed [34:0] den2_w;
        logic signed [34:0] num_c;
        logic signed [34:0] n2_c;
        num_w  = $signed({7'b0, t4_ff_reg}) + $signed({3'b0, t4_dd_reg})
                 - $signed({7'b0, t4_tt_reg});
        n2_w   = $signed({7'b0, t4_ff_reg}) + $signed({7'b0, t4_tt_reg})
                 - $signed({3'b0, t4_dd_reg});
        den_w  = $signed({4'b0, t4_den_reg});
        den2_w = $signed({6'b0, t4_den2_reg});
        num_c  = (num_w > den_w) ? den_w : ((num_w < -den_w) ? -den_w : num_w);
        n2_c   = (n2_w > den2_w) ? den2_w : ((n2_w < -den2_w) ? -den2_w : n2_w);
        t5_num_next = 32'(num_c);
        t5_n2_next  = 30'(n2_c);
        priority if ({1'b0, t4_d_reg} > ({3'b0, femur_len_reg} + {3'b0, tibia_len_reg}))
        begin
            t5_status_next = ST_REACH;
        end
        else if (t4_d_reg == '0)
        begin
            t5_status_next = ST_ZERO;
        end
        else if ((num_w > den_w) || (num_w < -den_w))
        begin
            t5_status_next = ST_COS;
        end
        else
        begin
            t5_status_next = ST_OK;
        end
    end

    // T6: squares for the sine terms
    solve_t      t6_side_reg;
    logic [61:0] t6_den_sq_reg;
    logic [61:0] t6_num_sq_reg;
    logic [61:0] t6_den2_sq_reg;
    logic [61:0] t6_n2_sq_reg;
    logic        t6_vld_reg;
    logic [63:0] t6_num_sq;
    logic [59:0] t6_n2_sq;

    always_comb
    begin
        logic signed [63:0] nsq;
        logic signed [59:0] n2sq;
        nsq       = t5_side_reg.num * t5_side_reg.num;
        n2sq      = t5_side_reg.n2 * t5_side_reg.n2;
        t6_num_sq = $unsigned(nsq);
        t6_n2_sq  = $unsigned(n2sq);
    end

    // T7: den^2 - num^2 and den2^2 - n2^2
    solve_t      t7_side_reg;
    logic [61:0] t7_diff1_reg;
    logic [61:0] t7_diff2_reg;
    logic        t7_vld_reg;

    logic                c_vld;
    logic [1:0][30:0]    c_root;
    solve_t              c_side;

    lik_isqrt #(
        .W      (62),
        .LANES  (2),
        .SIDE_W ($bits(solve_t))
    ) u_isqrt_sin (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (t7_vld_reg),
        .rad       ({t7_diff2_reg, t7_diff1_reg}),
        .in_side   (t7_side_reg),
        .out_valid (c_vld),
        .root      (c_root),
        .out_side  (c_side)
    );

    // angles: coxa, knee term a2, pitch a1, tibia a3
    logic [3:0][CORDIC_IN_W-1:0] k_y;
    logic [3:0][CORDIC_IN_W-1:0] k_x;
    tag_t                        k_tag;
    logic                        k_vld;
    logic [3:0][ACC_W-1:0]       k_angle;
    tag_t                        k_tag_out;

    always_comb
    begin
        k_y[0] = CORDIC_IN_W'(c_side.item.y);
        k_x[0] = CORDIC_IN_W'(c_side.item.x);
        k_y[1] = {1'b0, c_root[0]};
        k_x[1] = c_side.num;
        k_y[2] = -CORDIC_IN_W'(c_side.item.z);
        k_x[2] = CORDIC_IN_W'(c_side.h);
        k_y[3] = {1'b0, c_root[1]};
        k_x[3] = CORDIC_IN_W'(c_side.n2);
        k_tag.up     = c_side.item.up;
        k_tag.status = c_side.status;
    end

    lik_cordic #(
        .STAGES (CORDIC_STAGES),
        .LANES  (4),
        .SIDE_W ($bits(tag_t))
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (c_vld),
        .yin       (k_y),
        .xin       (k_x),
        .in_side   (k_tag),
        .out_valid (k_vld),
        .angle     (k_angle),
        .out_side  (k_tag_out)
    );

    // T8: round coxa, clamp partial angles
    tag_t                    t8_tag_reg;
    logic signed [19:0]      t8_coxa_reg;
    logic signed [ACC_W-1:0] t8_a1_reg;
    logic signed [ACC_W-1:0] t8_a2_reg;
    logic signed [ACC_W-1:0] t8_a3_reg;
    logic                    t8_vld_reg;

    // T9: clamp coxa, femur sum, round tibia
    tag_t                    t9_tag_reg;
    logic signed [ANG_W-1:0] t9_coxa_reg;
    logic signed [ACC_W:0]   t9_fsum_reg;
    logic signed [19:0]      t9_tib_reg;
    logic                    t9_vld_reg;
    logic signed [ANG_W-1:0] t9_coxa_next;

    always_comb
    begin
        if (t8_coxa_reg > 20'(COXA_LIM))
        begin
            t9_coxa_next = COXA_LIM;
        end
        else if (t8_coxa_reg < -20'(COXA_LIM))
        begin
            t9_coxa_next = -COXA_LIM;
        end
        else
        begin
            t9_coxa_next = t8_coxa_reg[ANG_W-1:0];
        end
    end

    // output register
    logic signed [ANG_W-1:0]   out_coxa_reg;
    logic signed [FEMUR_W-1:0] out_femur_reg;
    logic signed [ANG_W-1:0]   out_tibia_reg;
    status_t                   out_status_reg;
    logic                      out_vld_reg;
    logic signed [19:0]        fem_rnd;
    logic signed [19:0]        tib_sgn;

    assign fem_rnd = rnd16(t9_fsum_reg);
    assign tib_sgn = t9_tag_reg.up ? -t9_tib_reg : t9_tib_reg;

    assign en = !out_vld_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_vld_reg  <= 1'b0;
            t2_vld_reg  <= 1'b0;
            t3_vld_reg  <= 1'b0;
            t4_vld_reg  <= 1'b0;
            t5_vld_reg  <= 1'b0;
            t6_vld_reg  <= 1'b0;
            t7_vld_reg  <= 1'b0;
            t8_vld_reg  <= 1'b0;
            t9_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            t1_vld_reg  <= front_vld;
            t2_vld_reg  <= a_vld;
            t3_vld_reg  <= t2_vld_reg;
            t4_vld_reg  <= b_vld;
            t5_vld_reg  <= t4_vld_reg;
            t6_vld_reg  <= t5_vld_reg;
            t7_vld_reg  <= t6_vld_reg;
            t8_vld_reg  <= k_vld;
            t9_vld_reg  <= t8_vld_reg;
            out_vld_reg <= t9_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_item_reg <= front;
            t1_sq_reg   <= t1_sq_next;

            t2_item_reg <= a_item;
            t2_h_reg    <= t2_h_next;
            t2_zz_reg   <= t2_zz_next;

            t3_side_reg.item <= t2_item_reg;
            t3_side_reg.h    <= t2_h_reg;
            t3_sum_reg       <= t3_sum_next;

            t4_side_reg <= b_side;
            t4_d_reg    <= b_root;
            t4_ff_reg   <= 28'(femur_len_reg) * 28'(femur_len_reg);
            t4_tt_reg   <= 28'(tibia_len_reg) * 28'(tibia_len_reg);
            t4_dd_reg   <= 32'(b_root) * 32'(b_root);
            t4_den_reg  <= {t4_fd, 1'b0};
            t4_den2_reg <= {t4_ft, 1'b0};

            t5_side_reg.item   <= t4_side_reg.item;
            t5_side_reg.h      <= t4_side_reg.h;
            t5_side_reg.num    <= t5_num_next;
            t5_side_reg.n2     <= t5_n2_next;
            t5_side_reg.status <= t5_status_next;
            t5_den_reg         <= t4_den_reg;
            t5_den2_reg        <= t4_den2_reg;

            t6_side_reg    <= t5_side_reg;
            t6_den_sq_reg  <= 62'(t5_den_reg) * 62'(t5_den_reg);
            t6_num_sq_reg  <= t6_num_sq[61:0];
            t6_den2_sq_reg <= 62'(t5_den2_reg) * 62'(t5_den2_reg);
            t6_n2_sq_reg   <= 62'(t6_n2_sq);

            t7_side_reg  <= t6_side_reg;
            t7_diff1_reg <= t6_den_sq_reg - t6_num_sq_reg;
            t7_diff2_reg <= t6_den2_sq_reg - t6_n2_sq_reg;

            t8_tag_reg  <= k_tag_out;
            t8_coxa_reg <= rnd16((ACC_W+1)'($signed(k_angle[0])));
            t8_a2_reg   <= clamp_acc($signed(k_angle[1]), '0, HALF_TURN);
            t8_a1_reg   <= clamp_acc($signed(k_angle[2]), -HALF_TURN, HALF_TURN);
            t8_a3_reg   <= clamp_acc($signed(k_angle[3]), '0, HALF_TURN);

            t9_tag_reg  <= t8_tag_reg;
            t9_coxa_reg <= t9_coxa_next;
            t9_fsum_reg <= t8_tag_reg.up
                           ? (ACC_W+1)'(t8_a1_reg) - (ACC_W+1)'(t8_a2_reg)
                           : (ACC_W+1)'(t8_a1_reg) + (ACC_W+1)'(t8_a2_reg);
            t9_tib_reg  <= rnd16((ACC_W+1)'(t8_a3_reg));

            out_coxa_reg   <= t9_coxa_reg;
            out_status_reg <= t9_tag_reg.status;
            if (t9_tag_reg.status == ST_OK)
            begin
                out_femur_reg <= fem_rnd[FEMUR_W-1:0];
                out_tibia_reg <= tib_sgn[ANG_W-1:0];
            end
            else
            begin
                out_femur_reg <= '0;
                out_tibia_reg <= '0;
            end
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {7'b0, out_tibia_reg, out_femur_reg, out_coxa_reg};
    assign m_axis_tuser  = out_status_reg;

    // failed solves carry zero femur and tibia angles
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (out_status_reg != ST_OK))
        |-> ((out_femur_reg == '0) && (out_tibia_reg == '0)))
        else $error("femur/tibia not zero on failed solve");

    // the skid register only fills while the pipeline is held
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg |-> $past(!en))
        else $error("skid register full without a stall");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((out_coxa_reg <= COXA_LIM) && (out_coxa_reg >= -COXA_LIM)))
        else $error("coxa angle outside half turn");

endmodule

// ----- verif/tb_top.sv -----
module tb_top;
    import lik_pkg::*;

    typedef struct {
        logic signed [ANG_W-1:0]   coxa;
        logic signed [FEMUR_W-1:0] femur;
        logic signed [ANG_W-1:0]   tibia;
        status_t                   status;
    } joint_angles_t;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 120;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [47:0]          s_axis_tdata = '0;
    logic                 s_axis_tuser = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [55:0]          m_axis_tdata;
    logic [1:0]           m_axis_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [LEN_W-1:0]     cfg_data = '0;

    longint        coxa_len = 4160;
    longint        femur_len = 4160;
    longint        tibia_len = 6080;
    joint_angles_t pending_angles[$];
    int            mismatches = 0;
    int            poses_sent = 0;
    int            results_checked = 0;
    int            status_seen[4] = '{0, 0, 0, 0};
    int            cycle_count = 0;
    bit            tx_idle = 1'b1;
    bit            rx_idle = 1'b1;
    bit            rx_hold = 1'b0;

    leg_inverse_kinematics_top dut (.*);

    always #5 clk = ~clk;

    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // angle in 2^-16 steps of 1/128 degree
    function automatic longint cordic_angle(longint y, longint x);
        longint acc, nx, ny;
        acc = 0;
        if (x == 0 && y == 0) return 0;
        x *= 65536;
        y *= 65536;
        if (x < 0)
        begin
            acc = (y >= 0) ? longint'(HALF_TURN) : -longint'(HALF_TURN);
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STAGES_DEF && i < TAB_LEN; i++)
        begin
            if (y > 0)
            begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                acc += longint'(ATAN_TAB[i]);
            end
            else
            begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                acc -= longint'(ATAN_TAB[i]);
            end
            x = nx;
            y = ny;
        end
        return acc;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint drop_frac(longint v);
        if (v >= 0) return (v + 32768) / 65536;
        return -((-v + 32768) / 65536);
    endfunction

    function automatic joint_angles_t solve_leg(longint x, longint y, longint z, bit up);
        joint_angles_t r;
        longint h, d, num, den, n2, den2, a1, a2, a3, ht, femur, tibia;
        longint unsigned s;
        ht = longint'(HALF_TURN);
        femur = 0;
        tibia = 0;
        r.coxa = ANG_W'(clip(drop_frac(cordic_angle(y, x)), -23040, 23040));
        h = longint'(floor_sqrt(x * x + y * y)) - coxa_len;
        d = longint'(floor_sqrt(h * h + z * z));
        num = femur_len * femur_len + d * d - tibia_len * tibia_len;
        den = 2 * femur_len * d;
        if (d > femur_len + tibia_len) r.status = ST_REACH;
        else if (d == 0) r.status = ST_ZERO;
        else if (num > den || num < -den) r.status = ST_COS;
        else
        begin
            r.status = ST_OK;
            s = floor_sqrt(longint'(den * den) - longint'(num * num));
            a2 = clip(cordic_angle(longint'(s), num), 0, ht);
            a1 = clip(cordic_angle(-z, h), -ht, ht);
            den2 = 2 * femur_len * tibia_len;
            n2 = clip(femur_len * femur_len + tibia_len * tibia_len - d * d, -den2, den2);
            s = floor_sqrt(longint'(den2 * den2) - longint'(n2 * n2));
            a3 = clip(cordic_angle(longint'(s), n2), 0, ht);
            femur = drop_frac(up ? a1 - a2 : a1 + a2);
            tibia = drop_frac(a3);
            if (up) tibia = -tibia;
        end
        r.femur = FEMUR_W'(femur);
        r.tibia = ANG_W'(tibia);
        return r;
    endfunction

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_angles.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // predict on every accepted request
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            pending_angles.push_back(solve_leg(
                longint'($signed(s_axis_tdata[15:0])),
                longint'($signed(s_axis_tdata[31:16])),
                longint'($signed(s_axis_tdata[47:32])), s_axis_tuser));
    end

    always @(posedge clk)
    begin
        joint_angles_t want;
        logic signed [ANG_W-1:0]   got_coxa;
        logic signed [FEMUR_W-1:0] got_femur;
        logic signed [ANG_W-1:0]   got_tibia;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_coxa  = m_axis_tdata[15:0];
            got_femur = m_axis_tdata[32:16];
            got_tibia = m_axis_tdata[48:33];
            results_checked++;
            status_seen[m_axis_tuser]++;
            if (pending_angles.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result coxa=%0d femur=%0d tibia=%0d status=%0d",
                             got_coxa, got_femur, got_tibia, m_axis_tuser);
            end
            else
            begin
                want = pending_angles.pop_front();
                if (got_coxa !== want.coxa || got_femur !== want.femur ||
                    got_tibia !== want.tibia || m_axis_tuser !== want.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %0d/%0d/%0d st %0d, got %0d/%0d/%0d st %0d",
                                 want.coxa, want.femur, want.tibia, want.status,
                                 got_coxa, got_femur, got_tibia, m_axis_tuser);
                end
            end
        end
    end

    // long output stall, counted here
    always @(posedge clk)
    begin
        int held;
        if (rx_hold)
        begin
            held = 0;
            while (held < 400)
            begin
                @(posedge clk);
                held++;
            end
            rx_hold <= 1'b0;
        end
    end

    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            gap = rx_idle ? $urandom_range(0, 16) : 0;
            if (gap > 0 || rx_hold)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
                while (rx_hold) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    task automatic send_pose(input int x, input int y, input int z, input bit up);
        int gap;
        gap = tx_idle ? $urandom_range(0, 16) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata  <= {z[15:0], y[15:0], x[15:0]};
        s_axis_tuser  <= up;
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        poses_sent++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_angles.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_link(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_index <= idx;
        cfg_data  <= val[LEN_W-1:0];
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_COXA:  coxa_len  = val;
            REG_FEMUR: femur_len = val;
            REG_TIBIA: tibia_len = val;
            default: ;
        endcase
    endtask

    task automatic set_links(input int c, input int f, input int t);
        wait_idle();
        write_link(REG_COXA, c);
        write_link(REG_FEMUR, f);
        write_link(REG_TIBIA, t);
    endtask

    // mostly targets near the leg's workspace, some anywhere
    task automatic send_random_pose();
        int span;
        span = ($urandom_range(0, 3) == 0) ? 32767 : int'(femur_len + tibia_len + coxa_len);
        if (span > 32767) span = 32767;
        if ($urandom_range(0, 3) == 0)
            send_pose($urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
        else
            send_pose($urandom_range(0, 2 * span) - span, $urandom_range(0, 2 * span) - span,
                      $urandom_range(0, 2 * span) - span, 1'($urandom_range(0, 1)));
    endtask

    task automatic test_directed();
        send_pose(0, 0, 0, 0);              // all three coordinates zero
        send_pose(0, 0, 3000, 1);
        send_pose(-5000, 0, 100, 0);        // negative x axis
        send_pose(32767, 32767, 32767, 0);  // far beyond reach
        send_pose(-32768, -32768, -32768, 1);
        send_pose(-32768, 32767, 0, 0);
        send_pose(4160, 0, 0, 0);           // zero planar distance
        send_pose(4170, 0, 0, 1);           // cosine out of range
        send_pose(6080, 0, 0, 0);           // cosine right at the limit, folded
        send_pose(14400, 0, 0, 1);          // exactly at full reach
        send_pose(14401, 0, 0, 0);
        send_pose(9000, 3000, -4000, 0);
        send_pose(9000, 3000, -4000, 1);
        send_pose(0, -9000, 5000, 1);
        send_pose(-7000, -7000, -2000, 0);
        send_pose(1, 0, -10000, 1);
    endtask

    task automatic test_link_settings();
        set_links(0, 1, 1);
        repeat (20) send_random_pose();
        send_pose(1, 0, 0, 0);
        send_pose(0, 0, 2, 1);
        set_links(16383, 16383, 16383);
        repeat (20) send_random_pose();
        send_pose(16383, 0, 0, 0);
        send_pose(32767, 0, 0, 1);
        set_links(16383, 1, 16383);
        repeat (20) send_random_pose();
        set_links(0, 16383, 1);
        repeat (20) send_random_pose();
        set_links(2000, 5000, 7000);
        repeat (20) send_random_pose();
    endtask

    task automatic test_random();
        for (int i = 0; i < 450; i++)
        begin
            if (i % 100 == 0)
            begin
                tx_idle = ($urandom_range(0, 2) != 0);
                rx_idle = ($urandom_range(0, 2) != 0);
            end
            send_random_pose();
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    task automatic test_output_stall();
        tx_idle = 1'b0;
        rx_hold = 1'b1;
        repeat (200) send_random_pose();
        tx_idle = 1'b1;
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_link_settings();
        set_links(4160, 4160, 6080);
        test_random();
        test_output_stall();
        set_links(int'($urandom_range(0, 16383)), int'($urandom_range(1, 16383)),
                  int'($urandom_range(1, 16383)));
        repeat (40) send_random_pose();
        wait_idle();
        $display("%0d poses sent, %0d solutions checked over 7 link settings", poses_sent,
                 results_checked);
        $display("status counts: ok %0d, reach %0d, cosine %0d, zero %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- leg_inverse_kinematics_top.f -----
sv/lik_pkg.sv
sv/lik_isqrt.sv
sv/lik_cordic.sv
sv/leg_inverse_kinematics_top.sv
verif/tb_top.sv
